>>> rtl/kmeans_nearest_centroid_sse_core_assert.svh
// Assertion macros for the k-means error core.
`ifndef KMEANS_NEAREST_CENTROID_SSE_CORE_ASSERT_SVH
`define KMEANS_NEAREST_CENTROID_SSE_CORE_ASSERT_SVH

`ifndef SYNTH
`define KNC_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("check failed");
`define KNC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("check failed");
`else
`define KNC_ASSERT_ALWAYS(lbl, expr)
`define KNC_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

>>> rtl/knc_pkg.sv
`default_nettype none
package knc_pkg;
  localparam int CIDX_W = 4;
  localparam int EIDX_W = 10;
  localparam int VAL_W = 16;
  localparam int SQ_W = 32;
  localparam int ACC_W = 43;
  localparam int SUM_W = 64;
  localparam int CFGK_W = 5;
  localparam int CFGD_W = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTROIDS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS = 1'b1;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_DROP = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CIDX_W-1:0] cidx;
    logic [EIDX_W-1:0] eidx;
    logic [VAL_W-1:0]  val;
    logic              last;
  } knc_item_t;

  typedef struct packed {
    logic [1:0] fill;
  } knc_front_stat_t;

  typedef struct packed {
    logic busy;
  } knc_back_stat_t;
endpackage
`default_nettype wire

>>> rtl/knc_ram.sv
`default_nettype none
module knc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/knc_front.sv
`default_nettype none
module knc_front #(
  parameter int MAX_CENTROIDS = 16,
  parameter int MAX_DIMS = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          action_i,
  input  wire logic [knc_pkg::CIDX_W-1:0]    centroid_index_i,
  input  wire logic [knc_pkg::EIDX_W-1:0]    element_index_i,
  input  wire logic [knc_pkg::VAL_W-1:0]     element_value_i,
  input  wire logic                          last_in_set_i,
  output logic                               item_valid_o,
  input  wire logic                          item_ready_i,
  output knc_pkg::knc_item_t                 item_o,
  output knc_pkg::knc_front_stat_t           stat_o
);
  import knc_pkg::*;

  knc_item_t  slot_q [2];
  knc_item_t  new_item;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push, pop, in_range;

  always_comb begin
    in_range = (32'(centroid_index_i) < MAX_CENTROIDS) && (32'(element_index_i) < MAX_DIMS);
    new_item.cidx = centroid_index_i;
    new_item.eidx = element_index_i;
    new_item.val  = element_value_i;
    new_item.last = last_in_set_i;
    if (action_i) begin
      new_item.kind = KIND_DATA;
    end else if (in_range) begin
      new_item.kind = KIND_LOAD;
    end else begin
      new_item.kind = KIND_DROP;
    end
  end

  assign in_ready_o   = (fill_q != 2'd2);
  assign item_valid_o = (fill_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;
  assign stat_o.fill  = fill_q;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= new_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/knc_back.sv
`default_nettype none
module knc_back #(
  parameter int MAX_CENTROIDS = 16,
  parameter int MAX_DIMS = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          item_valid_i,
  output logic                               item_ready_o,
  input  wire knc_pkg::knc_item_t            item_i,
  input  wire logic [knc_pkg::CFGK_W-1:0]    cfg_k_i,
  input  wire logic [knc_pkg::CFGD_W-1:0]    cfg_d_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [knc_pkg::SUM_W-1:0]          total_error_o,
  output logic                               saturated_o,
  output knc_pkg::knc_back_stat_t            stat_o
);
  import knc_pkg::*;

  localparam int KW  = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
  localparam int KNW = $clog2(MAX_CENTROIDS + 1);
  localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DNW = $clog2(MAX_DIMS + 1);
  localparam int DEPTH = MAX_CENTROIDS * MAX_DIMS;
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [KW-1:0]    k_q;
  logic [DW-1:0]    cnt_q;
  logic [VAL_W-1:0] val_q;
  logic             last_q;
  logic [SQ_W-1:0]  sq_q;
  logic [ACC_W-1:0] best_q;
  logic [ACC_W-1:0] acc_q [MAX_CENTROIDS];
  logic [SUM_W-1:0] sum_q;
  logic             clip_q;

  logic [KNW-1:0]   kn;
  logic [DNW-1:0]   dn;
  logic             ram_we;
  logic [AW-1:0]    waddr, raddr;
  logic [VAL_W-1:0] rdata;
  logic [VAL_W:0]   diff;
  logic [VAL_W-1:0] mag;
  logic [ACC_W:0]   acc_sum;
  logic [ACC_W-1:0] acc_new;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_new;
  logic             clip_new, complete, last_k, emit_ok;

  always_comb begin
    if (cfg_k_i == '0) begin
      kn = KNW'(1);
    end else if (32'(cfg_k_i) > MAX_CENTROIDS) begin
      kn = KNW'(MAX_CENTROIDS);
    end else begin
      kn = KNW'(cfg_k_i);
    end
    if (cfg_d_i == '0) begin
      dn = DNW'(1);
    end else if (32'(cfg_d_i) > MAX_DIMS) begin
      dn = DNW'(MAX_DIMS);
    end else begin
      dn = DNW'(cfg_d_i);
    end
  end

  assign item_ready_o = (state_q == S_IDLE);
  assign ram_we = item_valid_i && item_ready_o && (item_i.kind == KIND_LOAD);
  assign waddr  = AW'(32'(item_i.cidx) * MAX_DIMS + 32'(item_i.eidx));
  assign raddr  = AW'(32'(k_q) * MAX_DIMS + 32'(cnt_q));

  knc_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (item_i.val),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    diff     = {1'b0, val_q} - {1'b0, rdata};
    mag      = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
    acc_sum  = {1'b0, acc_q[k_q]} + (ACC_W + 1)'(sq_q);
    acc_new  = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
    last_k   = (32'(k_q) + 1) >= 32'(kn);
    complete = (32'(cnt_q) + 1) >= 32'(dn);
    // add nearest distance only when the point is done
    sum_add  = {1'b0, sum_q} + (complete ? (SUM_W + 1)'(best_q) : '0);
    sum_new  = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    clip_new = clip_q || sum_add[SUM_W];
    emit_ok  = !out_valid_o || out_ready_i;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (item_valid_i && item_i.kind == KIND_DATA) state_d = S_RD;
      end
      S_RD:  state_d = S_SQ;
      S_SQ:  state_d = S_ACC;
      S_ACC: state_d = last_k ? S_FIN : S_RD;
      S_FIN: begin
        if (!last_q || emit_ok) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && item_valid_i) begin
      val_q  <= item_i.val;
      last_q <= item_i.last;
    end
    if (state_q == S_SQ) begin
      sq_q <= mag * mag;
    end
    if (state_q == S_ACC && (k_q == '0 || acc_new < best_q)) begin
      best_q <= acc_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      k_q           <= '0;
      cnt_q         <= '0;
      sum_q         <= '0;
      clip_q        <= 1'b0;
      out_valid_o   <= 1'b0;
      total_error_o <= '0;
      saturated_o   <= 1'b0;
      for (int i = 0; i < MAX_CENTROIDS; i++) acc_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_o && out_ready_i && !(state_q == S_FIN && last_q)) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: k_q <= '0;
        S_ACC: begin
          acc_q[k_q] <= acc_new;
          if (!last_k) k_q <= k_q + KW'(1);
        end
        S_FIN: begin
          if (last_q) begin
            if (emit_ok) begin
              out_valid_o   <= 1'b1;
              total_error_o <= sum_new;
              saturated_o   <= clip_new;
              sum_q         <= '0;
              clip_q        <= 1'b0;
              cnt_q         <= '0;
              for (int i = 0; i < MAX_CENTROIDS; i++) acc_q[i] <= '0;
            end
          end else if (complete) begin
            sum_q  <= sum_new;
            clip_q <= clip_new;
            cnt_q  <= '0;
            for (int i = 0; i < MAX_CENTROIDS; i++) acc_q[i] <= '0;
          end else begin
            cnt_q <= cnt_q + DW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign stat_o.busy = (state_q != S_IDLE);
endmodule
`default_nettype wire

>>> rtl/kmeans_nearest_centroid_sse_core.sv
// Nearest-centroid squared-error accumulator. Load items (action 0) write one
// Q0.16 centroid element into an on-chip store of MAX_CENTROIDS x MAX_DIMS
// entries; the engine writes a load while idle. Data items (action 1) stream
// point elements in order; each is matched against the K centroids in use in
// turn, since the centroid store has one read port and each centroid takes a
// read, a square and an accumulate step. A two-entry input queue decouples
// acceptance from the engine. When a point's last element arrives, the
// smallest distance is added to a saturating 64-bit sum; a data item flagged
// last_in_set emits the sum and a sticky saturation flag and clears both.
// Store entries are undefined until written. Write configuration only while
// idle.
`default_nettype none
module kmeans_nearest_centroid_sse_core #(
  parameter int MAX_CENTROIDS = 16,
  parameter int MAX_DIMS = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [knc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [knc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             action_i,
  input  wire logic [knc_pkg::CIDX_W-1:0]       centroid_index_i,
  input  wire logic [knc_pkg::EIDX_W-1:0]       element_index_i,
  input  wire logic [knc_pkg::VAL_W-1:0]        element_value_i,
  input  wire logic                             last_in_set_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [knc_pkg::SUM_W-1:0]             total_error_o,
  output logic                                  saturated_o
);
  import knc_pkg::*;

  logic [CFGK_W-1:0] cfg_k_q;
  logic [CFGD_W-1:0] cfg_d_q;
  knc_item_t         item;
  logic              item_valid, item_ready;
  knc_front_stat_t   front_stat;
  knc_back_stat_t    back_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_k_q <= CFGK_W'(1);
      cfg_d_q <= CFGD_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CENTROIDS: cfg_k_q <= cfg_data_i[CFGK_W-1:0];
        CFG_DIMS:      cfg_d_q <= cfg_data_i[CFGD_W-1:0];
        default: ;
      endcase
    end
  end

  knc_front #(.MAX_CENTROIDS(MAX_CENTROIDS), .MAX_DIMS(MAX_DIMS)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .centroid_index_i (centroid_index_i),
    .element_index_i  (element_index_i),
    .element_value_i  (element_value_i),
    .last_in_set_i    (last_in_set_i),
    .item_valid_o     (item_valid),
    .item_ready_i     (item_ready),
    .item_o           (item),
    .stat_o           (front_stat)
  );

  knc_back #(.MAX_CENTROIDS(MAX_CENTROIDS), .MAX_DIMS(MAX_DIMS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_ready_o  (item_ready),
    .item_i        (item),
    .cfg_k_i       (cfg_k_q),
    .cfg_d_i       (cfg_d_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .total_error_o (total_error_o),
    .saturated_o   (saturated_o),
    .stat_o        (back_stat)
  );

`include "kmeans_nearest_centroid_sse_core_assert.svh"

  `KNC_ASSERT_IMPL(a_sat_max, out_valid_o && saturated_o, total_error_o == {SUM_W{1'b1}})
  `KNC_ASSERT_ALWAYS(a_fill_bound, front_stat.fill != 2'd3)
  `KNC_ASSERT_IMPL(a_emit_from_busy, $rose(out_valid_o), $past(back_stat.busy))
endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import knc_pkg::*;

  localparam int NUM_K = 16;
  localparam int NUM_D = 1024;
  localparam logic [42:0] DIST_MAX = {43{1'b1}};
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DATA = 1'b1;
  localparam int SLOW_ITEM = 3 * NUM_K + 2;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int TOTAL_ITEMS = 1800;

  typedef enum logic { ROW_ITEM, ROW_REGS } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic        act;
    logic [3:0]  cidx;
    logic [9:0]  eidx;
    logic [15:0] val;
    logic        last;
    logic        typed;
    logic [63:0] total;
    logic        sat;
  } row_t;

  typedef struct packed {
    logic [63:0] total;
    logic        sat;
  } sse_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic action_i = 1'b0;
  logic [CIDX_W-1:0] centroid_index_i = '0;
  logic [EIDX_W-1:0] element_index_i = '0;
  logic [VAL_W-1:0] element_value_i = '0;
  logic last_in_set_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [SUM_W-1:0] total_error_o;
  logic saturated_o;

  kmeans_nearest_centroid_sse_core dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [15:0] cent_mem [NUM_K][NUM_D];
  bit          cent_written [NUM_K][NUM_D];
  logic [42:0] dist_acc [NUM_K];
  int unsigned elem_cnt;
  logic [63:0] sse_sum;
  logic        sse_clip;
  logic [10:0] reg_k, reg_d;

  sse_result_t sse_q[$];
  int errors = 0;
  int n_loads = 0, n_data = 0, n_results = 0;
  int unsigned cycles = 0;
  bit hold_long = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("kmeans_nearest_centroid_sse_core test failed");
      $finish;
    end
  end

  function automatic int unsigned k_used();
    logic [4:0] k;
    k = reg_k[4:0];
    if (k == 0) return 1;
    if (k > NUM_K) return NUM_K;
    return k;
  endfunction

  function automatic int unsigned d_used();
    if (reg_d == 0) return 1;
    if (reg_d > NUM_D) return NUM_D;
    return reg_d;
  endfunction

  function automatic void clear_point();
    for (int k = 0; k < NUM_K; k++) dist_acc[k] = '0;
    elem_cnt = 0;
  endfunction

  // returns 1 when the item emits a total
  function automatic bit step_sse(input logic act, input logic [3:0] ci, input logic [9:0] ei,
                                  input logic [15:0] v, input logic lst,
                                  output sse_result_t res);
    int unsigned kn, pos;
    logic [15:0] diff;
    logic [42:0] sq, best;
    if (act == ACT_LOAD) begin
      cent_mem[ci][ei] = v;
      cent_written[ci][ei] = 1;
      return 0;
    end
    kn = k_used();
    pos = (elem_cnt >= NUM_D) ? NUM_D - 1 : elem_cnt;
    for (int k = 0; k < kn; k++) begin
      diff = (v >= cent_mem[k][pos]) ? v - cent_mem[k][pos] : cent_mem[k][pos] - v;
      sq = 43'(diff) * 43'(diff);
      dist_acc[k] = (dist_acc[k] > DIST_MAX - sq) ? DIST_MAX : dist_acc[k] + sq;
    end
    if (elem_cnt + 1 >= d_used()) begin
      best = dist_acc[0];
      for (int k = 1; k < kn; k++) if (dist_acc[k] < best) best = dist_acc[k];
      if (64'(best) > ~sse_sum) begin
        sse_sum = '1;
        sse_clip = 1'b1;
      end else begin
        sse_sum = sse_sum + 64'(best);
      end
      clear_point();
    end else begin
      elem_cnt++;
    end
    if (!lst) return 0;
    res.total = sse_sum;
    res.sat = sse_clip;
    sse_sum = '0;
    sse_clip = 1'b0;
    clear_point();
    return 1;
  endfunction

  task automatic drive_raw(input logic act, input logic [3:0] ci, input logic [9:0] ei,
                           input logic [15:0] v, input logic lst, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    centroid_index_i <= ci;
    element_index_i <= ei;
    element_value_i <= v;
    last_in_set_i <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    if (act == ACT_LOAD) n_loads++;
    else n_data++;
  endtask

  // send one item; typed rows override the predicted total
  task automatic send_item(input logic act, input logic [3:0] ci, input logic [9:0] ei,
                           input logic [15:0] v, input logic lst, input bit gaps,
                           input bit typed, input sse_result_t typed_res);
    sse_result_t res;
    int unsigned pos;
    logic [15:0] fillv;
    if (act == ACT_DATA) begin
      // load any centroid element this data item would read
      pos = (elem_cnt >= NUM_D) ? NUM_D - 1 : elem_cnt;
      for (int k = 0; k < k_used(); k++) begin
        if (!cent_written[k][pos]) begin
          fillv = 16'($urandom);
          void'(step_sse(ACT_LOAD, 4'(k), 10'(pos), fillv, 1'b0, res));
          drive_raw(ACT_LOAD, 4'(k), 10'(pos), fillv, 1'($urandom), gaps);
        end
      end
    end
    if (step_sse(act, ci, ei, v, lst, res)) sse_q.push_back(typed ? typed_res : res);
    drive_raw(act, ci, ei, v, lst, gaps);
  endtask

  task automatic wait_idle();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (sse_q.size() != 0) @(posedge clk_i);
    repeat (3 * SLOW_ITEM + 10) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [10:0] k, input logic [10:0] d);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_CENTROIDS;
    cfg_data_i <= k;
    @(posedge clk_i);
    cfg_index_i <= CFG_DIMS;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reg_k = k & 11'h1F;
    reg_d = d;
  endtask

  // result checker with random back-pressure
  initial begin
    int stall;
    forever begin
      stall = hold_long ? 400 : $urandom_range(0, 8);
      hold_long = 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      n_results++;
      if (sse_q.size() == 0) begin
        $display("%0t unexpected total: %h sat %b", $time, total_error_o, saturated_o);
        errors++;
      end else begin
        if (total_error_o !== sse_q[0].total) begin
          $display("%0t total mismatch: expected %h actual %h", $time, sse_q[0].total,
                   total_error_o);
          errors++;
        end
        if (saturated_o !== sse_q[0].sat) begin
          $display("%0t saturated mismatch: expected %b actual %b", $time, sse_q[0].sat,
                   saturated_o);
          errors++;
        end
        void'(sse_q.pop_front());
      end
    end
  end

  row_t rows[$];

  function automatic row_t item_row(input logic act, input logic [3:0] ci, input logic [9:0] ei,
                                    input logic [15:0] v, input logic lst, input logic typed,
                                    input logic [63:0] total);
    row_t r;
    r.kind = ROW_ITEM; r.act = act; r.cidx = ci; r.eidx = ei; r.val = v; r.last = lst;
    r.typed = typed; r.total = total; r.sat = 1'b0;
    return r;
  endfunction

  function automatic row_t regs_row(input logic [10:0] k, input logic [10:0] d);
    row_t r;
    r = item_row(ACT_LOAD, 0, 0, 0, 0, 0, 0);
    r.kind = ROW_REGS; r.cidx = 4'(k); r.eidx = 10'(d);
    return r;
  endfunction

  initial begin
    sse_result_t tres;
    int kk, dd;
    bit done_point;
    logic lst;
    for (int k = 0; k < NUM_K; k++)
      for (int e = 0; e < NUM_D; e++) begin
        cent_mem[k][e] = '0;
        cent_written[k][e] = 0;
      end
    clear_point();
    sse_sum = '0;
    sse_clip = 1'b0;
    reg_k = 1;
    reg_d = 1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one centroid, one dimension after reset
    rows.push_back(item_row(ACT_LOAD, 0, 0, 16'h0000, 0, 0, 0));
    rows.push_back(item_row(ACT_DATA, 0, 0, 16'hFFFF, 1, 1, 64'hFFFE0001));
    rows.push_back(item_row(ACT_LOAD, 0, 0, 16'hFFFF, 1, 0, 0));
    rows.push_back(item_row(ACT_DATA, 9, 77, 16'h0000, 1, 1, 64'hFFFE0001));
    rows.push_back(item_row(ACT_DATA, 0, 0, 16'hFFFF, 1, 1, 64'h0));
    rows.push_back(item_row(ACT_DATA, 0, 0, 16'h8000, 0, 0, 0));
    rows.push_back(item_row(ACT_DATA, 0, 0, 16'h0001, 1, 0, 0));
    rows.push_back(item_row(ACT_LOAD, 15, 1023, 16'hABCD, 0, 0, 0));
    rows.push_back(item_row(ACT_LOAD, 3, 5, 16'h5555, 0, 0, 0));
    rows.push_back(regs_row(3, 3));
    rows.push_back(item_row(ACT_DATA, 0, 0, 16'h1111, 0, 0, 0));
    rows.push_back(item_row(ACT_DATA, 0, 0, 16'hEEEE, 1, 0, 0));
    rows.push_back(regs_row(2, 4));
    rows.push_back(item_row(ACT_DATA, 0, 0, 16'h0F0F, 0, 0, 0));
    rows.push_back(item_row(ACT_DATA, 0, 0, 16'hF0F0, 0, 0, 0));
    rows.push_back(item_row(ACT_DATA, 0, 0, 16'h3C3C, 0, 0, 0));
    // lower dims with the counter past the new end
    rows.push_back(regs_row(2, 2));
    rows.push_back(item_row(ACT_DATA, 0, 0, 16'h7777, 1, 0, 0));
    rows.push_back(regs_row(0, 0));
    rows.push_back(item_row(ACT_DATA, 0, 0, 16'h1234, 1, 0, 0));
    rows.push_back(regs_row(11'h7FF, 2));
    rows.push_back(item_row(ACT_DATA, 0, 0, 16'hFFFF, 0, 0, 0));
    rows.push_back(item_row(ACT_DATA, 0, 0, 16'h0000, 1, 0, 0));
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REGS) begin
        write_regs(11'(rows[i].cidx), 11'(rows[i].eidx));
      end else begin
        tres.total = rows[i].total;
        tres.sat = rows[i].sat;
        send_item(rows[i].act, rows[i].cidx, rows[i].eidx, rows[i].val, rows[i].last, 1,
                  rows[i].typed, tres);
      end
    end

    // long point with dims out of range acting as the maximum, then cut short
    write_regs(0, 11'h7FF);
    for (int e = 0; e < 256; e++)
      send_item(ACT_DATA, 0, 0, 16'($urandom), 1'b0, $urandom_range(0, 3) == 0, 0, tres);
    write_regs(0, 2);
    send_item(ACT_DATA, 0, 0, 16'($urandom), 1'b1, 1, 0, tres);
    write_regs(16, 8);
    for (int e = 0; e < 16; e++)
      send_item(ACT_DATA, 0, 0, 16'($urandom), e == 15, 0, 0, tres);

    // hold the receiver while totals pile up
    write_regs(4, 1);
    hold_long = 1;
    for (int i = 0; i < 24; i++) send_item(ACT_DATA, 0, 0, 16'($urandom), 1, 0, 0, tres);

    while (n_loads + n_data < TOTAL_ITEMS) begin
      kk = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
      dd = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) dd = $urandom_range(0, 2047) & 11'h00F;
      write_regs(11'(kk) | (11'($urandom) & 11'h7E0), 11'(dd));
      for (int i = 0; i < 150 && n_loads + n_data < TOTAL_ITEMS; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          send_item(ACT_LOAD, 4'($urandom), ($urandom_range(0, 3) == 0) ? 10'($urandom)
                    : 10'($urandom_range(0, d_used() - 1)), 16'($urandom), 1'($urandom),
                    1, 0, tres);
        end else begin
          done_point = (elem_cnt + 1 >= d_used());
          lst = done_point ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 49) == 0);
          send_item(ACT_DATA, 4'($urandom), 10'($urandom),
                    ($urandom_range(0, 7) == 0) ? {16{1'($urandom)}} : 16'($urandom),
                    lst, $urandom_range(0, 4) != 0, 0, tres);
        end
      end
    end
    send_item(ACT_DATA, 0, 0, 16'($urandom), 1, 1, 0, tres);

    in_valid_i <= 1'b0;
    while (sse_q.size() != 0) @(posedge clk_i);
    repeat (3 * SLOW_ITEM + 10) @(posedge clk_i);
    if (sse_q.size() != 0) begin
      $display("%0t %0d totals never arrived", $time, sse_q.size());
      errors++;
    end
    $display("Sent %0d centroid loads and %0d point elements; checked %0d totals.",
             n_loads, n_data, n_results);
    $display("Covered 1 to 16 centroids, dims up to the maximum, out-of-range registers,");
    $display("dims lowered mid-point, a long output stall and early set ends.");
    if (errors == 0) begin
      $display("kmeans_nearest_centroid_sse_core test passed");
    end else begin
      $display("kmeans_nearest_centroid_sse_core test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/knc_pkg.sv
rtl/knc_ram.sv
rtl/knc_front.sv
rtl/knc_back.sv
rtl/kmeans_nearest_centroid_sse_core.sv
tb/tb_top.sv
